FILE: sv/ordered_key_value_table_core_defines.svh
// assertion macros used by ordered_key_value_table_core.sv
`ifndef ORDERED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define OKVT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define OKVT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OKVT_ASSERT(label, prop, msg)
`define OKVT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: sv/okvt_pkg.sv
package okvt_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_PUT           = 2'd0,
		OP_PUT_IF_ABSENT = 2'd1,
		OP_GET           = 2'd2,
		OP_REMOVE        = 2'd3
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_ZERO_KEY = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [CNT_W-1:0]      count_t;

	// per-cell control from the table controller
	typedef struct packed {
		logic valid;
		logic write_val;
		logic load_new;
		logic shift;
	} cell_ctrl_t;

endpackage

FILE: sv/okvt_req_if.sv
interface okvt_req_if import okvt_pkg::*; ();
	logic     valid;
	logic     ready;
	op_kind_t kind;
	key_t     lookup_key;
	value_t   new_value;

	modport source (output valid, kind, lookup_key, new_value, input ready);
	modport sink (input valid, kind, lookup_key, new_value, output ready);
endinterface

FILE: sv/okvt_rsp_if.sv
interface okvt_rsp_if import okvt_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	logic    hit;
	value_t  old_value;
	count_t  entry_count;

	modport source (output valid, status, hit, old_value, entry_count, input ready);
	modport sink (input valid, status, hit, old_value, entry_count, output ready);
endinterface

FILE: sv/okvt_cell.sv
module okvt_cell import okvt_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  key_t       lookup_key,
	input  value_t     new_value,
	input  key_t       next_key,
	input  value_t     next_value,
	output key_t       key,
	output value_t     value,
	output logic       match
);

	key_t   key_q;
	value_t value_q;

	assign match = ctrl.valid && (key_q == lookup_key);
	assign key   = key_q;
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q   <= next_key;
			value_q <= next_value;
		end else if (ctrl.load_new) begin
			key_q   <= lookup_key;
			value_q <= new_value;
		end else if (ctrl.write_val) begin
			value_q <= new_value;
		end
	end

endmodule

FILE: sv/ordered_key_value_table_core.sv
// channel  dir  payload
// req      in   kind, lookup_key, new_value
// rsp      out  status, hit, old_value, entry_count
//
// one item per cycle unless rsp stalls: all cells compare their key in parallel,
// the result is registered and shows in the cycle after the item is taken
// a remove shifts every cell past the match down by one in that same cycle
// req.ready is high while the response register is empty or being drained
// reset clears the entry count and the response valid; cell contents need none
`include "ordered_key_value_table_core_defines.svh"

module ordered_key_value_table_core import okvt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	okvt_req_if.sink   req,
	okvt_rsp_if.source rsp
);

	count_t     occ_q;
	logic       rsp_valid_q;
	status_t    status_q;
	logic       hit_q;
	value_t     old_q;
	count_t     count_q;

	key_t       cell_key [CAPACITY];
	value_t     cell_val [CAPACITY];
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] at_or_after;
	cell_ctrl_t ctrl [CAPACITY];

	logic    accept, key_zero, is_put, hit, full, do_insert, do_remove;
	value_t  old_value;
	status_t status_d;
	count_t  occ_d;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign key_zero  = (req.lookup_key == '0);
	assign is_put    = (req.kind == OP_PUT) || (req.kind == OP_PUT_IF_ABSENT);
	assign hit       = !key_zero && (|match_vec);
	assign full      = (occ_q == count_t'(CAPACITY));
	assign do_insert = !key_zero && is_put && !hit && !full;
	assign do_remove = (req.kind == OP_REMOVE) && hit;

	// keys are unique, so at most one cell matches
	always_comb begin
		old_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_vec[i])
				old_value = old_value | cell_val[i];
		end
		if (key_zero)
			old_value = '0;
	end

	always_comb begin
		if (key_zero)
			status_d = ST_ZERO_KEY;
		else if (is_put && !hit && full)
			status_d = ST_FULL;
		else
			status_d = ST_DONE;
		if (do_insert)
			occ_d = occ_q + count_t'(1);
		else if (do_remove)
			occ_d = occ_q - count_t'(1);
		else
			occ_d = occ_q;
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			key_t   nk;
			value_t nv;

			if (g == 0) begin : g_first
				assign at_or_after[g] = match_vec[g];
			end else begin : g_rest
				assign at_or_after[g] = at_or_after[g-1] | match_vec[g];
			end

			if (g == CAPACITY - 1) begin : g_last
				assign nk = '0;
				assign nv = '0;
			end else begin : g_mid
				assign nk = cell_key[g+1];
				assign nv = cell_val[g+1];
			end

			always_comb begin
				ctrl[g].valid     = count_t'(g) < occ_q;
				ctrl[g].write_val = accept && !key_zero && (req.kind == OP_PUT)
					&& match_vec[g];
				ctrl[g].load_new  = accept && do_insert && (occ_q == count_t'(g));
				ctrl[g].shift     = accept && do_remove && at_or_after[g];
			end

			okvt_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl[g]),
				.lookup_key (req.lookup_key),
				.new_value  (req.new_value),
				.next_key   (nk),
				.next_value (nv),
				.key        (cell_key[g]),
				.value      (cell_val[g]),
				.match      (match_vec[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q       <= occ_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			hit_q    <= hit;
			old_q    <= old_value;
			count_q  <= occ_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.hit         = hit_q;
	assign rsp.old_value   = old_q;
	assign rsp.entry_count = count_q;

	`OKVT_ASSERT(a_unique_keys, $onehot0(match_vec), "more than one cell holds the key")
	`OKVT_ASSERT_ALWAYS(a_occ_range, !arst_n || occ_q <= count_t'(CAPACITY), "count too big")
	`OKVT_ASSERT(a_remove_shrinks, accept && do_remove |=> occ_q == $past(occ_q) - count_t'(1), "remove did not shrink table")
	`OKVT_ASSERT(a_full_clean, rsp_valid_q && status_q == ST_FULL |-> !hit_q && old_q == '0, "full response carries data")

endmodule
